// ===== rtl/asso_pkg.sv =====
// Shared types and constants for the atomic semaphore set block.
// Used by every module in rtl/; depends on nothing else.
package asso_pkg;

    localparam int IDX_W = 6;
    localparam int VAL_W = 16;
    localparam int POS_W = 5;
    localparam int CFG_W = 7;

    localparam int DEF_NUM_SEMS = 64;
    localparam int DEF_MAX_OPS  = 32;
    localparam logic [CFG_W-1:0] NUM_SEMS_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_SEMOP  = 2'd0,
        OP_SET    = 2'd1,
        OP_GET    = 2'd2,
        OP_GET_LR = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_NOWAIT   = 3'd1,
        STATUS_WAIT     = 3'd2,
        STATUS_BADIDX   = 3'd3,
        STATUS_TOOMANY  = 3'd4,
        STATUS_OVERFLOW = 3'd5
    } status_t;

    // One buffered semop element.
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] amt;
        logic                    no_wait;
    } pend_entry_t;

    // Write strobes for the semaphore store.
    typedef struct packed {
        logic sem_we;
        logic lr_we;
    } store_ctl_t;

endpackage

// ===== rtl/asso_pend_buf.sv =====
// Pending semop element buffer: one synchronous memory, one write and one read port.
// Depends on asso_pkg for the element type.
module asso_pend_buf
    import asso_pkg::*;
#(
    parameter int MAX_OPS = DEF_MAX_OPS,
    localparam int PA_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [PA_W-1:0]   waddr,
    input  pend_entry_t       wdata,
    input  logic [PA_W-1:0]   raddr,
    output pend_entry_t       rdata
);

    pend_entry_t mem [MAX_OPS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/asso_sem_store.sv =====
// Semaphore value and last-requester memories, each with one write and one read port.
// Depends on asso_pkg for the write strobe struct and field widths.
module asso_sem_store
    import asso_pkg::*;
#(
    parameter int SEM_DEPTH = DEF_NUM_SEMS,
    localparam int SEM_AW = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1
) (
    input  logic               aclk,
    input  store_ctl_t         ctl,
    input  logic [SEM_AW-1:0]  sem_waddr,
    input  logic [VAL_W-1:0]   sem_wdata,
    input  logic [SEM_AW-1:0]  lr_waddr,
    input  logic [VAL_W-1:0]   lr_wdata,
    input  logic [SEM_AW-1:0]  raddr,
    output logic [VAL_W-1:0]   sem_rdata,
    output logic [VAL_W-1:0]   lr_rdata
);

    logic [VAL_W-1:0] sem_mem [SEM_DEPTH];
    logic [VAL_W-1:0] lr_mem  [SEM_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.sem_we) begin
            sem_mem[sem_waddr] <= sem_wdata;
        end
        sem_rdata <= sem_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.lr_we) begin
            lr_mem[lr_waddr] <= lr_wdata;
        end
        lr_rdata <= lr_mem[raddr];
    end

endmodule

// ===== rtl/atomic_semaphore_set_ops_core.sv =====
// Top level of the atomic semaphore set block: control sequencer and result register.
// Depends on asso_pkg, asso_pend_buf and asso_sem_store.
//
// Usage: items enter on the s_ channel (valid/ready) and results leave on the m_
// channel (valid/ready). A semop element (opcode 0) without last_op is buffered and
// gives no result; when the buffer is full it is dropped and flags too-many-ops. The
// element marked last starts a walk over the buffered vector: each element is read
// from the value memory, then checked and written back; a failing vector is undone
// element by element back to position zero, and a successful one then records the
// requester for each element. Set, bad-index and too-many-ops items go straight to
// the result state; get items first pass a read state for the registered read of
// the value or last-requester memory. One item is worked on at a time; a finished
// result sits in the output register while the next item is taken, and the block
// waits only when a second result is ready before the first is taken. After reset
// both memories are cleared by a sweep over all min(NUM_SEMS, 64) entries, during
// which s_ready stays low. The user must write num_semaphores through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module atomic_semaphore_set_ops_core
    import asso_pkg::*;
#(
    parameter int NUM_SEMS = DEF_NUM_SEMS,
    parameter int MAX_OPS  = DEF_MAX_OPS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_opcode,
    input  logic [IDX_W-1:0]        s_sem_index,
    input  logic signed [VAL_W-1:0] s_op_amount,
    input  logic [VAL_W-1:0]        s_set_value,
    input  logic                    s_no_wait,
    input  logic                    s_last_op,
    input  logic [VAL_W-1:0]        s_requester_id,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2:0]              m_status,
    output logic [VAL_W-1:0]        m_read_value,
    output logic [POS_W-1:0]        m_failed_position
);

    localparam int SEM_DEPTH = (NUM_SEMS < (1 << IDX_W)) ? NUM_SEMS : (1 << IDX_W);
    localparam int SEM_AW    = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1;
    localparam int PA_W      = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int CNT_W     = $clog2(MAX_OPS + 1);

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_PEND_RD = 7'b0000100,
        ST_SEM_RD  = 7'b0001000,
        ST_EXEC    = 7'b0010000,
        ST_READ    = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        MODE_APPLY = 3'b001,
        MODE_UNDO  = 3'b010,
        MODE_STAMP = 3'b100
    } walk_mode_t;

    state_t            state_reg, state_next;
    walk_mode_t        mode_reg, mode_next;
    logic [PA_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [SEM_AW-1:0] clr_reg, clr_next;
    logic [CFG_W-1:0]  num_sem_reg;
    logic              m_valid_reg, m_valid_next;

    logic [VAL_W-1:0]        req_reg, req_next;
    logic                    rd_lr_reg, rd_lr_next;
    logic [IDX_W-1:0]        elem_idx_reg, elem_idx_next;
    logic signed [VAL_W-1:0] elem_amt_reg, elem_amt_next;
    logic                    elem_nw_reg, elem_nw_next;
    status_t                 res_status_reg, res_status_next;
    logic [VAL_W-1:0]        res_rv_reg, res_rv_next;
    logic [POS_W-1:0]        res_pos_reg, res_pos_next;
    status_t                 out_status_reg, out_status_next;
    logic [VAL_W-1:0]        out_rv_reg, out_rv_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;

    store_ctl_t        st_ctl;
    logic [SEM_AW-1:0] sem_waddr, lr_waddr, sem_raddr;
    logic [VAL_W-1:0]  sem_wdata, lr_wdata, sem_rdata, lr_rdata;

    logic              pend_we;
    pend_entry_t       pend_wdata, pend_rdata;

    logic              s_idx_ok, p_idx_ok, buf_full, ptr_is_last, out_free;
    logic              fail;
    status_t           fail_code;
    logic signed [VAL_W+1:0] new_val;
    logic              amt_neg, amt_zero, blocked, val_ovf;

    asso_pend_buf #(
        .MAX_OPS (MAX_OPS)
    ) u_pend_buf (
        .aclk  (aclk),
        .we    (pend_we),
        .waddr (PA_W'(count_reg)),
        .wdata (pend_wdata),
        .raddr (ptr_next),
        .rdata (pend_rdata)
    );

    asso_sem_store #(
        .SEM_DEPTH (SEM_DEPTH)
    ) u_sem_store (
        .aclk      (aclk),
        .ctl       (st_ctl),
        .sem_waddr (sem_waddr),
        .sem_wdata (sem_wdata),
        .lr_waddr  (lr_waddr),
        .lr_wdata  (lr_wdata),
        .raddr     (sem_raddr),
        .sem_rdata (sem_rdata),
        .lr_rdata  (lr_rdata)
    );

    assign s_idx_ok = ({1'b0, s_sem_index} < num_sem_reg) && (int'(s_sem_index) < NUM_SEMS);
    assign p_idx_ok = ({1'b0, pend_rdata.idx} < num_sem_reg)
                      && (int'(pend_rdata.idx) < NUM_SEMS);
    assign buf_full    = (count_reg >= CNT_W'(MAX_OPS));
    assign ptr_is_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == n_reg);
    assign out_free    = !m_valid_reg || m_ready;

    assign pend_wdata.idx     = s_sem_index;
    assign pend_wdata.amt     = s_op_amount;
    assign pend_wdata.no_wait = s_no_wait;

    assign sem_raddr = (state_reg == ST_IDLE) ? SEM_AW'(s_sem_index) : SEM_AW'(pend_rdata.idx);

    // Value check for the element in the execute cycle; sem_rdata holds its current value.
    assign new_val  = $signed({2'b00, sem_rdata})
                      + $signed({{2{elem_amt_reg[VAL_W-1]}}, elem_amt_reg});
    assign amt_neg  = elem_amt_reg[VAL_W-1];
    assign amt_zero = (elem_amt_reg == '0);
    assign blocked  = (amt_neg && new_val[VAL_W+1]) || (amt_zero && (sem_rdata != '0));
    assign val_ovf  = !amt_neg && !amt_zero && new_val[VAL_W];

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        ptr_next        = ptr_reg;
        n_next          = n_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        clr_next        = clr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        req_next        = req_reg;
        rd_lr_next      = rd_lr_reg;
        elem_idx_next   = elem_idx_reg;
        elem_amt_next   = elem_amt_reg;
        elem_nw_next    = elem_nw_reg;
        res_status_next = res_status_reg;
        res_rv_next     = res_rv_reg;
        res_pos_next    = res_pos_reg;
        out_status_next = out_status_reg;
        out_rv_next     = out_rv_reg;
        out_pos_next    = out_pos_reg;
        st_ctl          = '0;
        sem_waddr       = SEM_AW'(elem_idx_reg);
        sem_wdata       = new_val[VAL_W-1:0];
        lr_waddr        = SEM_AW'(pend_rdata.idx);
        lr_wdata        = req_reg;
        pend_we         = 1'b0;
        s_ready         = 1'b0;
        fail            = 1'b0;
        fail_code       = STATUS_OK;

        case (state_reg)
            ST_CLEAR: begin
                st_ctl.sem_we = 1'b1;
                st_ctl.lr_we  = 1'b1;
                sem_waddr     = clr_reg;
                sem_wdata     = '0;
                lr_waddr      = clr_reg;
                lr_wdata      = '0;
                clr_next      = clr_reg + SEM_AW'(1);
                if (clr_reg == SEM_AW'(SEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                ptr_next = '0;
                if (s_valid) begin
                    res_rv_next  = '0;
                    res_pos_next = '0;
                    case (s_opcode)
                        OP_SEMOP: begin
                            if (buf_full) begin
                                ovf_next = 1'b1;
                            end else begin
                                pend_we    = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            if (s_last_op) begin
                                count_next = '0;
                                ovf_next   = 1'b0;
                                if (ovf_reg || buf_full) begin
                                    res_status_next = STATUS_TOOMANY;
                                    state_next      = ST_DONE;
                                end else begin
                                    n_next     = count_reg + CNT_W'(1);
                                    mode_next  = MODE_APPLY;
                                    req_next   = s_requester_id;
                                    state_next = ST_PEND_RD;
                                end
                            end
                        end
                        default: begin
                            if (!s_idx_ok) begin
                                res_status_next = STATUS_BADIDX;
                                state_next      = ST_DONE;
                            end else if (s_opcode == OP_SET) begin
                                st_ctl.sem_we   = 1'b1;
                                sem_waddr       = SEM_AW'(s_sem_index);
                                sem_wdata       = s_set_value;
                                res_status_next = STATUS_OK;
                                state_next      = ST_DONE;
                            end else begin
                                res_status_next = STATUS_OK;
                                rd_lr_next      = (s_opcode == OP_GET_LR);
                                state_next      = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_PEND_RD: begin
                state_next = ST_SEM_RD;
            end
            ST_SEM_RD: begin
                elem_idx_next = pend_rdata.idx;
                elem_amt_next = pend_rdata.amt;
                elem_nw_next  = pend_rdata.no_wait;
                if (mode_reg == MODE_STAMP) begin
                    st_ctl.lr_we = 1'b1;
                    if (ptr_is_last) begin
                        res_status_next = STATUS_OK;
                        res_rv_next     = '0;
                        res_pos_next    = '0;
                        state_next      = ST_DONE;
                    end else begin
                        ptr_next = ptr_reg + PA_W'(1);
                    end
                end else if (mode_reg == MODE_APPLY && !p_idx_ok) begin
                    fail      = 1'b1;
                    fail_code = STATUS_BADIDX;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (mode_reg == MODE_UNDO) begin
                    st_ctl.sem_we = 1'b1;
                    sem_wdata     = sem_rdata - $unsigned(elem_amt_reg);
                    if (ptr_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        ptr_next   = ptr_reg - PA_W'(1);
                        state_next = ST_SEM_RD;
                    end
                end else if (blocked) begin
                    fail      = 1'b1;
                    fail_code = elem_nw_reg ? STATUS_NOWAIT : STATUS_WAIT;
                end else if (val_ovf) begin
                    fail      = 1'b1;
                    fail_code = STATUS_OVERFLOW;
                end else begin
                    st_ctl.sem_we = 1'b1;
                    state_next    = ST_SEM_RD;
                    if (ptr_is_last) begin
                        // Whole vector applied: go back over it to record the requester.
                        ptr_next  = '0;
                        mode_next = MODE_STAMP;
                    end else begin
                        ptr_next = ptr_reg + PA_W'(1);
                    end
                end
            end
            ST_READ: begin
                res_rv_next = rd_lr_reg ? lr_rdata : sem_rdata;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_rv_next     = res_rv_reg;
                    out_pos_next    = res_pos_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A failing element undoes every earlier element, walking back to position zero.
        if (fail) begin
            res_status_next = fail_code;
            res_rv_next     = '0;
            res_pos_next    = POS_W'(ptr_reg);
            if (ptr_reg == '0) begin
                state_next = ST_DONE;
            end else begin
                ptr_next   = ptr_reg - PA_W'(1);
                mode_next  = MODE_UNDO;
                state_next = ST_SEM_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            mode_reg    <= MODE_APPLY;
            ptr_reg     <= '0;
            n_reg       <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            num_sem_reg <= NUM_SEMS_RESET;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            ptr_reg     <= ptr_next;
            n_reg       <= n_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                num_sem_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        rd_lr_reg      <= rd_lr_next;
        elem_idx_reg   <= elem_idx_next;
        elem_amt_reg   <= elem_amt_next;
        elem_nw_reg    <= elem_nw_next;
        res_status_reg <= res_status_next;
        res_rv_reg     <= res_rv_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_rv_reg     <= out_rv_next;
        out_pos_reg    <= out_pos_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_status_reg;
    assign m_read_value      = out_rv_reg;
    assign m_failed_position = out_pos_reg;

    a_walk_ptr_in_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEM_RD || state_reg == ST_EXEC) |-> (CNT_W'(ptr_reg) < n_reg))
        else $error("walk pointer left the buffered vector");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_OPS))
        else $error("pending element count exceeds the buffer depth");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result issued outside the done state");

    a_idle_write_is_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && st_ctl.sem_we) |-> (s_valid && s_opcode == OP_SET && s_idx_ok))
        else $error("value memory written in idle without a valid set item");

endmodule

// ===== tb/sv/atomic_semaphore_set_ops_core_tb.sv =====
// Self-checking testbench for atomic_semaphore_set_ops_core: directed and random items,
// checked against a behavioral model of the semaphore bank.
// Depends on asso_pkg and the RTL under rtl/.
module atomic_semaphore_set_ops_core_tb
    import asso_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_NUM_SEMS    = DEF_NUM_SEMS;
    localparam int TB_MAX_OPS     = DEF_MAX_OPS;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int GAP_PCT        = 12;

    typedef struct {
        opcode_t                 op;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] amt;
        logic [VAL_W-1:0]        setv;
        logic                    nw;
        logic                    last;
        logic [VAL_W-1:0]        req;
    } sem_item_t;

    typedef struct {
        status_t          status;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } reply_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_opcode = '0;
    logic [IDX_W-1:0]        s_sem_index = '0;
    logic signed [VAL_W-1:0] s_op_amount = '0;
    logic [VAL_W-1:0]        s_set_value = '0;
    logic                    s_no_wait = 1'b0;
    logic                    s_last_op = 1'b0;
    logic [VAL_W-1:0]        s_requester_id = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [2:0]              m_status;
    logic [VAL_W-1:0]        m_read_value;
    logic [POS_W-1:0]        m_failed_position;

    // Model of the bank: values, last requesters, the element buffer and the count register.
    logic [VAL_W-1:0]        bank_val   [TB_NUM_SEMS];
    logic [VAL_W-1:0]        bank_owner [TB_NUM_SEMS];
    logic [IDX_W-1:0]        vec_idx    [TB_MAX_OPS];
    int                      vec_amt    [TB_MAX_OPS];
    logic                    vec_nw     [TB_MAX_OPS];
    int                      vec_cnt = 0;
    bit                      vec_ovf = 1'b0;
    logic [CFG_W-1:0]        sems_in_use = NUM_SEMS_RESET;

    reply_t                  replies_due [$];
    int                      mismatches = 0;
    int                      items_sent = 0;
    int                      idle_cycles = 0;
    bit                      src_gaps = 1'b1;
    bit                      sink_gaps = 1'b1;

    atomic_semaphore_set_ops_core #(
        .NUM_SEMS(TB_NUM_SEMS),
        .MAX_OPS (TB_MAX_OPS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_sem_index      (s_sem_index),
        .s_op_amount      (s_op_amount),
        .s_set_value      (s_set_value),
        .s_no_wait        (s_no_wait),
        .s_last_op        (s_last_op),
        .s_requester_id   (s_requester_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_read_value     (m_read_value),
        .m_failed_position(m_failed_position)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Works out the result of one accepted item and updates the bank model.
    function automatic void bank_apply(input sem_item_t it);
        reply_t r;
        int     lim;
        int     cur;
        int     nxt;
        bit     failed;
        r.status = STATUS_OK;
        r.value  = '0;
        r.pos    = '0;
        lim = (sems_in_use > TB_NUM_SEMS) ? TB_NUM_SEMS : int'(sems_in_use);
        if (it.op == OP_SEMOP) begin
            if (vec_cnt < TB_MAX_OPS) begin
                vec_idx[vec_cnt] = it.idx;
                vec_amt[vec_cnt] = it.amt;
                vec_nw[vec_cnt]  = it.nw;
                vec_cnt++;
            end else begin
                vec_ovf = 1'b1;
            end
            if (!it.last)
                return;
            if (vec_ovf) begin
                r.status = STATUS_TOOMANY;
            end else begin
                failed = 1'b0;
                for (int i = 0; i < vec_cnt && !failed; i++) begin
                    if (vec_idx[i] >= lim) begin
                        r.status = STATUS_BADIDX;
                    end else begin
                        cur = bank_val[vec_idx[i]];
                        nxt = cur + vec_amt[i];
                        if ((vec_amt[i] < 0 && nxt < 0) || (vec_amt[i] == 0 && cur > 0)) begin
                            if (vec_nw[i])
                                r.status = STATUS_NOWAIT;
                            else
                                r.status = STATUS_WAIT;
                        end else if (vec_amt[i] > 0 && nxt > 65535) begin
                            r.status = STATUS_OVERFLOW;
                        end else begin
                            bank_val[vec_idx[i]] = nxt[VAL_W-1:0];
                        end
                    end
                    if (r.status != STATUS_OK) begin
                        // Undo every element applied so far, newest first.
                        failed = 1'b1;
                        r.pos  = i[POS_W-1:0];
                        for (int j = i - 1; j >= 0; j--)
                            bank_val[vec_idx[j]] = bank_val[vec_idx[j]] - vec_amt[j][VAL_W-1:0];
                    end
                end
                if (!failed) begin
                    for (int i = 0; i < vec_cnt; i++)
                        bank_owner[vec_idx[i]] = it.req;
                end
            end
            vec_cnt = 0;
            vec_ovf = 1'b0;
        end else if (it.idx >= lim) begin
            r.status = STATUS_BADIDX;
        end else begin
            case (it.op)
                OP_SET:  bank_val[it.idx] = it.setv;
                OP_GET:  r.value = bank_val[it.idx];
                default: r.value = bank_owner[it.idx];
            endcase
        end
        replies_due.push_back(r);
    endfunction

    function automatic sem_item_t semop_elem(input logic [IDX_W-1:0] idx,
                                             input logic signed [VAL_W-1:0] amt,
                                             input logic nw, input logic last,
                                             input logic [VAL_W-1:0] req);
        sem_item_t it;
        it.op   = OP_SEMOP;
        it.idx  = idx;
        it.amt  = amt;
        it.setv = VAL_W'($urandom);
        it.nw   = nw;
        it.last = last;
        it.req  = req;
        return it;
    endfunction

    // Set and get items; the amount, no-wait, last and requester fields carry random values.
    function automatic sem_item_t plain_op(input opcode_t op, input logic [IDX_W-1:0] idx,
                                           input logic [VAL_W-1:0] setv);
        sem_item_t it;
        it.op   = op;
        it.idx  = idx;
        it.amt  = VAL_W'($urandom);
        it.setv = setv;
        it.nw   = 1'($urandom_range(1));
        it.last = 1'($urandom_range(1));
        it.req  = VAL_W'($urandom);
        return it;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(9) < 7)
            return IDX_W'($urandom_range(7));
        return IDX_W'($urandom_range(63));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_amount();
        int a;
        case ($urandom_range(9))
            0, 1, 2, 3: a = int'($urandom_range(8)) - 4;
            4:          a = 0;
            5, 6:       a = $urandom;
            7:          a = 32767 - int'($urandom_range(3));
            8:          a = -32768 + int'($urandom_range(3));
            default:    a = int'($urandom_range(600)) - 300;
        endcase
        return a[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] pick_set_value();
        case ($urandom_range(3))
            0:       return VAL_W'($urandom_range(10));
            1:       return VAL_W'($urandom);
            2:       return VAL_W'(32'hFFFF - $urandom_range(3));
            default: return VAL_W'($urandom_range(100, 1000));
        endcase
    endfunction

    // Offers one item and returns at the edge where it is accepted; valid is left high
    // so that the next item can follow without a gap.
    task automatic send_item(input sem_item_t it);
        @(negedge aclk);
        while (src_gaps && $urandom_range(99) < GAP_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= it.op;
        s_sem_index    <= it.idx;
        s_op_amount    <= it.amt;
        s_set_value    <= it.setv;
        s_no_wait      <= it.nw;
        s_last_op      <= it.last;
        s_requester_id <= it.req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bank_apply(it);
        items_sent++;
    endtask

    // Stops sending, waits for every outstanding result, then lets a buffered walk finish.
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_sem_count(input logic [CFG_W-1:0] count);
        settle_block();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sems_in_use = count;
    endtask

    task automatic test_reset_values();
        send_item(plain_op(OP_GET, 0, 0));
        send_item(plain_op(OP_GET, 63, 0));
        send_item(plain_op(OP_GET_LR, 0, 0));
        send_item(plain_op(OP_GET_LR, 63, 0));
    endtask

    task automatic test_set_get();
        send_item(plain_op(OP_SET, 0, 16'hFFFF));
        send_item(plain_op(OP_SET, 63, 16'h8001));
        send_item(plain_op(OP_GET, 0, 0));
        send_item(plain_op(OP_GET, 63, 0));
    endtask

    task automatic test_semop_outcomes();
        send_item(semop_elem(2, 3, 1'b0, 1'b1, 16'hFFFF));
        send_item(plain_op(OP_GET_LR, 2, 0));
        // Taking more than the value holds with no-wait set.
        send_item(semop_elem(2, -4, 1'b1, 1'b1, 16'h0001));
        // The third element blocks, so the two before it must be undone.
        send_item(semop_elem(2, -3, 1'b0, 1'b0, 16'h1234));
        send_item(semop_elem(3, 0, 1'b0, 1'b0, 16'h1234));
        send_item(semop_elem(2, -1, 1'b0, 1'b1, 16'h1234));
        send_item(plain_op(OP_GET, 2, 0));
        send_item(plain_op(OP_GET_LR, 3, 0));
        send_item(semop_elem(2, 0, 1'b1, 1'b1, 16'h4321));
        send_item(semop_elem(2, 0, 1'b0, 1'b1, 16'h4321));
        // The value at index 0 is at its maximum, so any give overflows.
        send_item(semop_elem(1, 5, 1'b0, 1'b0, 16'h7777));
        send_item(semop_elem(0, 1, 1'b0, 1'b1, 16'h7777));
        send_item(plain_op(OP_GET, 1, 0));
        send_item(semop_elem(0, -32768, 1'b0, 1'b1, 16'hA5A5));
        send_item(semop_elem(1, 32767, 1'b1, 1'b1, 16'h5A5A));
        send_item(plain_op(OP_GET, 0, 0));
        send_item(plain_op(OP_GET_LR, 1, 0));
    endtask

    task automatic test_vector_limits();
        for (int k = 0; k < TB_MAX_OPS; k++)
            send_item(semop_elem(4, 1, 1'b0, k == TB_MAX_OPS - 1, 16'hBEEF));
        // One element more than the buffer holds, then the last one.
        for (int k = 0; k <= TB_MAX_OPS + 1; k++)
            send_item(semop_elem(4, 1, 1'b0, k == TB_MAX_OPS + 1, 16'hDEAD));
        send_item(plain_op(OP_GET, 4, 0));
        send_item(plain_op(OP_GET_LR, 4, 0));
    endtask

    task automatic test_sem_count_extremes();
        program_sem_count(5);
        send_item(semop_elem(1, 1, 1'b0, 1'b0, 16'h0055));
        send_item(semop_elem(5, 1, 1'b0, 1'b1, 16'h0055));
        send_item(plain_op(OP_SET, 5, 16'h0009));
        send_item(plain_op(OP_GET, 1, 0));
        send_item(plain_op(OP_GET, 4, 0));
        program_sem_count(0);
        send_item(plain_op(OP_GET, 0, 0));
        send_item(plain_op(OP_GET_LR, 0, 0));
        send_item(semop_elem(0, 1, 1'b0, 1'b1, 16'h0066));
        program_sem_count(127);
        send_item(plain_op(OP_SET, 63, 16'h0003));
        send_item(plain_op(OP_GET, 63, 0));
        program_sem_count(1);
        send_item(plain_op(OP_GET, 0, 0));
        send_item(plain_op(OP_GET, 1, 0));
        send_item(semop_elem(0, 2, 1'b0, 1'b1, 16'h0077));
        program_sem_count(64);
    endtask

    // Mostly well-formed vectors over a few busy semaphores, mixed with sets, gets and noise.
    task automatic test_random_traffic(input int n_items);
        int          stop_at;
        int          pick;
        int          len;
        logic [15:0] req;
        sem_item_t   junk;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = ($urandom_range(29) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 5);
                req = 16'($urandom);
                for (int k = 0; k < len; k++)
                    send_item(semop_elem(pick_index(), pick_amount(), 1'($urandom_range(1)),
                                         k == len - 1, req));
            end else if (pick < 70) begin
                send_item(plain_op(OP_SET, pick_index(), pick_set_value()));
            end else if (pick < 84) begin
                send_item(plain_op(OP_GET, pick_index(), VAL_W'($urandom)));
            end else if (pick < 92) begin
                send_item(plain_op(OP_GET_LR, pick_index(), VAL_W'($urandom)));
            end else begin
                junk = plain_op(opcode_t'(2'($urandom_range(3))), IDX_W'($urandom_range(63)),
                                VAL_W'($urandom));
                send_item(junk);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TB_NUM_SEMS; i++) begin
            bank_val[i]   = '0;
            bank_owner[i] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_set_get();
        test_semop_outcomes();
        test_vector_limits();
        test_sem_count_extremes();
        test_random_traffic(80);
        settle_block();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        test_random_traffic(80);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        program_sem_count(CFG_W'($urandom_range(1, 64)));
        test_random_traffic(60);
        program_sem_count(127);
        test_random_traffic(40);
        program_sem_count(0);
        test_random_traffic(20);
        program_sem_count(64);
        test_random_traffic(110);
        settle_block();

        if (mismatches == 0 && replies_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= !(sink_gaps && $urandom_range(99) < GAP_PCT);
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result with none expected: status %0d value %0d position %0d",
                         $time, m_status, m_read_value, m_failed_position);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_status);
                    mismatches++;
                end
                if (m_read_value !== want.value) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.value, m_read_value);
                    mismatches++;
                end
                if (m_failed_position !== want.pos) begin
                    $display("%0t: failed_position expected %0d actual %0d",
                             $time, want.pos, m_failed_position);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/asso_pkg.sv
rtl/asso_pend_buf.sv
rtl/asso_sem_store.sv
rtl/atomic_semaphore_set_ops_core.sv
tb/sv/atomic_semaphore_set_ops_core_tb.sv
